/* hw/rtl/filtered_group_by_sum_count_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef FILTERED_GROUP_BY_SUM_COUNT_MACROS_SVH
`define FILTERED_GROUP_BY_SUM_COUNT_MACROS_SVH
// assert that an antecedent implies a consequent in the next cycle
`define FGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%s failed", "label");
// assert that an antecedent implies a consequent in the same cycle
`define FGB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%s failed", "label");
`endif

/* hw/rtl/fgbsc_pkg.sv */
// Package for the filtered group-by block: sizes, codes, control structs.
// No dependencies.
package fgbsc_pkg;
   localparam int NUM_GROUPS = 64;
   localparam int NUM_COLS   = 4;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = 6;
   localparam int KEY_W      = 4 * DATA_WIDTH;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   localparam logic [2:0] REG_FILTER_MASK = 3'd0;
   localparam logic [2:0] REG_ARG0        = 3'd1;
   localparam logic [2:0] REG_ARG1        = 3'd2;
   localparam logic [2:0] REG_ARG2        = 3'd3;
   localparam logic [2:0] REG_ARG3        = 3'd4;
   localparam logic [2:0] REG_GROUP_MASK  = 3'd5;
   localparam logic [2:0] REG_AGG_COLUMN  = 3'd6;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_GROUP = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MATCH, ST_READ, ST_UPDATE, ST_DRAIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture input beat
      logic update;    // write hit/fresh slot, form ack
      logic drain_emit;// form entry for current scan slot
      logic scan_next; // advance scan pointer
      logic empty_emit;// form empty-table result
      logic clear;     // clear valid bits
      logic out_set;   // output register is being loaded
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_drain;
      logic scan_valid;  // current scan slot is valid
      logic scan_any;    // any valid slot at or above scan pointer
      logic scan_end;    // no valid slot above current scan slot
   } status_type;
endpackage

/* hw/rtl/fgbsc_ctrl.sv */
// Controller state machine of the group-by block.
// Depends on fgbsc_pkg.
module fgbsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   out_busy,
   input  logic                   out_take,
   input  fgbsc_pkg::status_type  status,
   output fgbsc_pkg::cmd_type     cmd
);
   fgbsc_pkg::state_type state_ff, state_in;
   logic out_free;

   // output register can load when empty or being emptied
   assign out_free = !out_busy || out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fgbsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fgbsc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = fgbsc_pkg::ST_MATCH;
         end
         fgbsc_pkg::ST_MATCH: begin
            state_in = status.is_drain ? fgbsc_pkg::ST_DRAIN : fgbsc_pkg::ST_READ;
         end
         fgbsc_pkg::ST_READ: begin
            state_in = fgbsc_pkg::ST_UPDATE;
         end
         fgbsc_pkg::ST_UPDATE: begin
            if (out_free) state_in = fgbsc_pkg::ST_IDLE;
         end
         fgbsc_pkg::ST_DRAIN: begin
            if (out_free) begin
               if (!status.scan_any || status.scan_end) state_in = fgbsc_pkg::ST_IDLE;
            end
         end
         default: state_in = fgbsc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         fgbsc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         fgbsc_pkg::ST_UPDATE: begin
            if (out_free) begin
               cmd.update = 1'b1;
               cmd.out_set = 1'b1;
            end
         end
         fgbsc_pkg::ST_DRAIN: begin
            if (out_free) begin
               cmd.out_set = 1'b1;
               if (!status.scan_any) begin
                  cmd.empty_emit = 1'b1;
                  cmd.clear = 1'b1;
               end else if (status.scan_valid) begin
                  cmd.drain_emit = 1'b1;
                  cmd.scan_next = 1'b1;
                  cmd.clear = status.scan_end;
               end else begin
                  cmd.out_set = 1'b0;
                  cmd.scan_next = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end
endmodule

/* hw/rtl/fgbsc_datapath.sv */
// Datapath of the group-by block: config, slot table, compare, output register.
// Depends on fgbsc_pkg.
module fgbsc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_wdata,
   input  logic [7:0]              req_tuser,
   input  logic [127:0]            req_tdata,
   input  fgbsc_pkg::cmd_type      cmd,
   output fgbsc_pkg::status_type   status,
   output logic                    out_busy,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [255:0]            rsp_tdata,
   output logic [7:0]              rsp_tuser,
   output logic                    rsp_tlast
);
   localparam int DW = fgbsc_pkg::DATA_WIDTH;
   localparam int NG = fgbsc_pkg::NUM_GROUPS;
   localparam int SW = fgbsc_pkg::SLOT_W;

   logic [3:0]    filter_mask_ff, group_mask_ff;
   logic [1:0]    agg_column_ff;
   logic [DW-1:0] arg_ff [4];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mask_ff <= '0;
         group_mask_ff  <= 4'd2;
         agg_column_ff  <= 2'd2;
         for (int i = 0; i < 4; i++) arg_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            fgbsc_pkg::REG_FILTER_MASK: filter_mask_ff <= csr_wdata[3:0];
            fgbsc_pkg::REG_ARG0: arg_ff[0] <= csr_wdata[DW-1:0];
            fgbsc_pkg::REG_ARG1: arg_ff[1] <= csr_wdata[DW-1:0];
            fgbsc_pkg::REG_ARG2: arg_ff[2] <= csr_wdata[DW-1:0];
            fgbsc_pkg::REG_ARG3: arg_ff[3] <= csr_wdata[DW-1:0];
            fgbsc_pkg::REG_GROUP_MASK: group_mask_ff <= csr_wdata[3:0];
            fgbsc_pkg::REG_AGG_COLUMN: agg_column_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // capture input beat: key, filter result, aggregate value
   logic          drain_ff, sel_ff;
   logic [31:0]   key_ff [4];
   logic [31:0]   aggv_ff;
   logic          pass;
   logic [31:0]   col [4];
   always_comb begin
      pass = 1'b1;
      for (int c = 0; c < 4; c++) begin
         if (c < fgbsc_pkg::NUM_COLS) begin
            col[c] = 32'(signed'(req_tdata[32*c +: DW]));
            if (filter_mask_ff[c] && req_tdata[32*c +: DW] != arg_ff[c]) pass = 1'b0;
         end else begin
            col[c] = '0;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         drain_ff <= req_tuser[0];
         sel_ff   <= pass;
         for (int c = 0; c < 4; c++) key_ff[c] <= group_mask_ff[c] ? col[c] : '0;
         aggv_ff  <= col[agg_column_ff];
      end
   end

   // slot table
   logic [NG-1:0]  valid_ff;
   logic [127:0]   skey_ff [NG];
   logic [63:0]    ssum_ff [NG];
   logic [31:0]    scnt_ff [NG];
   logic [NG-1:0]  hit_vec_ff;
   logic [127:0]   key_cat;
   assign key_cat = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};

   // parallel compare, registered (load -> match cycle)
   always_ff @(posedge clock) begin
      for (int s = 0; s < NG; s++) hit_vec_ff[s] <= valid_ff[s] && (skey_ff[s] == key_cat);
   end

   // priority encode hit and free slot
   logic [SW-1:0] hit_idx, free_idx;
   logic          hit_any, free_any;
   always_comb begin
      hit_idx = '0; free_idx = '0; hit_any = 1'b0; free_any = 1'b0;
      for (int s = NG-1; s >= 0; s--) begin
         if (hit_vec_ff[s]) begin hit_idx = SW'(s); hit_any = 1'b1; end
         if (!valid_ff[s]) begin free_idx = SW'(s); free_any = 1'b1; end
      end
   end

   logic [SW-1:0] tgt;
   logic [63:0]   old_sum, new_sum;
   logic [31:0]   old_cnt, new_cnt;
   logic          do_write;
   logic [63:0]   sum_rd_ff;
   logic [31:0]   cnt_rd_ff;
   assign tgt      = hit_any ? hit_idx : free_idx;

   // register the target slot's sum and count ahead of the update
   always_ff @(posedge clock) begin
      sum_rd_ff <= ssum_ff[tgt];
      cnt_rd_ff <= scnt_ff[tgt];
   end

   assign old_sum  = hit_any ? sum_rd_ff : 64'd0;
   assign old_cnt  = hit_any ? cnt_rd_ff : 32'd0;
   assign new_sum  = old_sum + 64'(signed'(aggv_ff));
   assign new_cnt  = (old_cnt == fgbsc_pkg::COUNT_MAX) ? old_cnt : old_cnt + 32'd1;
   assign do_write = cmd.update && sel_ff && (hit_any || free_any);

   // scan pointer for drain
   logic [SW-1:0] scan_ff;
   logic [NG-1:0] above, above_next;
   always_comb begin
      for (int s = 0; s < NG; s++) begin
         above[s]      = valid_ff[s] && (SW'(s) >= scan_ff);
         above_next[s] = valid_ff[s] && (SW'(s) >  scan_ff);
      end
   end
   assign status.is_drain   = drain_ff;
   assign status.scan_valid = valid_ff[scan_ff];
   assign status.scan_any   = |above;
   assign status.scan_end   = ~|above_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         scan_ff  <= '0;
      end else begin
         if (cmd.load) scan_ff <= '0;
         else if (cmd.scan_next) scan_ff <= scan_ff + SW'(1);
         if (cmd.clear) valid_ff <= '0;
         else if (do_write) valid_ff[tgt] <= 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (do_write) begin
         skey_ff[tgt] <= key_cat;
         ssum_ff[tgt] <= new_sum;
         scnt_ff[tgt] <= new_cnt;
      end
   end

   // output register
   logic          ov_ff;
   logic [1:0]    okind_ff;
   logic          osel_ff, odrop_ff, olast_ff;
   logic [SW-1:0] oslot_ff;
   logic [127:0]  okey_ff;
   logic [63:0]   osum_ff;
   logic [31:0]   ocnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (cmd.out_set) begin
         ov_ff <= 1'b1;
      end else if (rsp_tready) begin
         ov_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         okind_ff <= fgbsc_pkg::KIND_ACK;
         osel_ff  <= sel_ff;
         odrop_ff <= sel_ff && !(hit_any || free_any);
         olast_ff <= 1'b1;
         oslot_ff <= do_write ? tgt : '0;
         okey_ff  <= sel_ff ? key_cat : '0;
         osum_ff  <= do_write ? new_sum : '0;
         ocnt_ff  <= do_write ? new_cnt : '0;
      end else if (cmd.drain_emit) begin
         okind_ff <= fgbsc_pkg::KIND_GROUP;
         osel_ff  <= 1'b0;
         odrop_ff <= 1'b0;
         olast_ff <= status.scan_end;
         oslot_ff <= scan_ff;
         okey_ff  <= skey_ff[scan_ff];
         osum_ff  <= ssum_ff[scan_ff];
         ocnt_ff  <= scnt_ff[scan_ff];
      end else if (cmd.empty_emit) begin
         okind_ff <= fgbsc_pkg::KIND_EMPTY;
         osel_ff  <= 1'b0;
         odrop_ff <= 1'b0;
         olast_ff <= 1'b1;
         oslot_ff <= '0;
         okey_ff  <= '0;
         osum_ff  <= '0;
         ocnt_ff  <= '0;
      end
   end
   assign out_busy   = ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = {4'd0, odrop_ff, osel_ff, okind_ff};
   assign rsp_tdata  = {26'd0, ocnt_ff, osum_ff, okey_ff, oslot_ff};
endmodule

/* hw/rtl/filtered_group_by_sum_count.sv */
// Filtered group-by with 64-bit sum and saturating count per group.
// Row: accepted in idle, compared in match, slot read in read, result registered
// in update, which waits while the output register is full and not being taken;
// no new row is accepted before the return to idle. Drain: one group entry per
// cycle while the output is free, with empty slots skipped one by one in the scan.
// Reset (synchronous, active high) clears the table and loads register defaults.
module filtered_group_by_sum_count (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,  // col0, col1, col2, col3
   input  logic [7:0]    req_tuser,  // req_type, zero fill
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [255:0]  rsp_tdata,  // slot, key0..key3, group_sum, group_count
   output logic [7:0]    rsp_tuser,  // kind, selected, dropped, zero fill
   output logic          rsp_tlast
);
   fgbsc_pkg::cmd_type    cmd;
   fgbsc_pkg::status_type status;
   logic                  out_busy;

   fgbsc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .out_busy, .out_take(rsp_tready), .status, .cmd
   );
   fgbsc_datapath u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tuser, .req_tdata, .cmd, .status, .out_busy,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );
endmodule

/* hw/rtl/fgbsc_checker.sv */
// Port-level checker for the group-by block, bound to the top level.
// Depends on filtered_group_by_sum_count_macros.svh and fgbsc_pkg.
`include "filtered_group_by_sum_count_macros.svh"
module fgbsc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [255:0] rsp_tdata,
   input logic [7:0]   rsp_tuser,
   input logic         rsp_tlast
);
   // a stalled result holds
   `FGB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // acknowledgements and empty drains are single-beat
   `FGB_ASSERT_NOW(a_ack_last, clock, reset, rsp_tvalid && rsp_tuser[1:0] != fgbsc_pkg::KIND_GROUP, rsp_tlast)
   // no beat taken the cycle after an accept
   `FGB_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   // a drop only on a selected row
   `FGB_ASSERT_NOW(a_drop_sel, clock, reset, rsp_tvalid && rsp_tuser[3], rsp_tuser[2])
endmodule

bind filtered_group_by_sum_count fgbsc_checker u_checker (.*);
